FILE: rtl/nofx_pkg.sv
package nofx_pkg;

  localparam int unsigned KeyWidth = 16;
  localparam int unsigned CfgIndexWidth = 4;

  typedef enum logic [1:0] {
    MODE_ALWAYS = 2'd0,
    MODE_NEVER  = 2'd1,
    MODE_SEQ    = 2'd2,
    MODE_TIME   = 2'd3
  } mode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_FILTER_MODE  = 4'd0,
    REG_PASS_COUNT   = 4'd1,
    REG_GROUP_SIZE   = 4'd2,
    REG_GROUP_OFFSET = 4'd3
  } reg_index_e;

  // one packet travelling down the divider chain
  typedef struct packed {
    logic                decided;
    logic                drop;
    logic [KeyWidth-1:0] key;
    logic [KeyWidth-1:0] dvd;
    logic [KeyWidth-1:0] rem;
  } item_t;

endpackage

FILE: rtl/nofx_div_cell.sv
module nofx_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [nofx_pkg::KeyWidth-1:0] divisor_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  nofx_pkg::item_t               item_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output nofx_pkg::item_t               item_o
);

  logic            valid_q;
  nofx_pkg::item_t item_q;
  nofx_pkg::item_t item_d;
  logic [nofx_pkg::KeyWidth:0] trial;

  // one restoring division step: bring down the next dividend bit
  always_comb begin
    item_d = item_i;
    trial  = {item_i.rem, item_i.dvd[nofx_pkg::KeyWidth-1]};
    if (trial >= {1'b0, divisor_i}) begin
      trial = trial - {1'b0, divisor_i};
    end
    item_d.rem = trial[nofx_pkg::KeyWidth-1:0];
    item_d.dvd = {item_i.dvd[nofx_pkg::KeyWidth-2:0], 1'b0};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/n_of_x_packet_filter_unit.sv
// N-of-X packet filter with offset.
// Input channel (in_valid_i / in_ready_o) carries one packet header per
// transfer: sequence count and timestamp. Output channel (out_valid_o /
// out_ready_i) returns one result per packet, in order: filtered_o (1 = drop)
// and key_value_o (sequence or time key, zero in always/never mode).
// Configuration channel (cfg_valid_i / cfg_ready_o) writes filter_mode,
// pass_count, group_size, group_offset by index 0..3; other indexes are
// ignored. cfg_ready_o is always high.
// out_valid_o follows the input transfer through one front stage and a chain
// of 16 restoring division cells (one remainder bit per cell) that forms
// (key - offset) mod group_size; 17 register stages.
// Throughput: one packet per cycle while the receiver does not stall.
// Reset clears all stage valid bits and loads register defaults
// (always drop, N = 1, X = 1, O = 0).
// When the receiver stalls, each stage holds until the one after it frees,
// so bubbles are squeezed out and the input keeps taking packets until the
// chain is full.
module n_of_x_packet_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nofx_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [15:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [13:0]                         seq_count_i,
  input  logic [31:0]                         time_seconds_i,
  input  logic [31:0]                         time_subseconds_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                filtered_o,
  output logic [15:0]                         key_value_o
);

  localparam int unsigned NumCells = nofx_pkg::KeyWidth;

  nofx_pkg::mode_e filter_mode_q;
  logic [15:0]     pass_count_q;
  logic [15:0]     group_size_q;
  logic [15:0]     group_offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_mode_q  <= nofx_pkg::MODE_ALWAYS;
      pass_count_q   <= 16'd1;
      group_size_q   <= 16'd1;
      group_offset_q <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        nofx_pkg::REG_FILTER_MODE:  filter_mode_q  <= nofx_pkg::mode_e'(cfg_data_i[1:0]);
        nofx_pkg::REG_PASS_COUNT:   pass_count_q   <= cfg_data_i;
        nofx_pkg::REG_GROUP_SIZE:   group_size_q   <= cfg_data_i;
        nofx_pkg::REG_GROUP_OFFSET: group_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front stage: key, parameter check, offset subtract
  nofx_pkg::item_t front_d;
  nofx_pkg::item_t front_q;
  logic            front_valid_q;
  logic            params_ok;

  assign params_ok = (group_size_q != 16'd0) && (pass_count_q != 16'd0) &&
                     (pass_count_q <= group_size_q) && (group_offset_q < group_size_q);

  always_comb begin
    front_d = '0;
    case (filter_mode_q)
      nofx_pkg::MODE_ALWAYS: begin
        front_d.decided = 1'b1;
        front_d.drop    = 1'b1;
      end
      nofx_pkg::MODE_NEVER: begin
        front_d.decided = 1'b1;
        front_d.drop    = 1'b0;
      end
      nofx_pkg::MODE_SEQ: begin
        front_d.key = {2'b00, seq_count_i};
      end
      nofx_pkg::MODE_TIME: begin
        front_d.key = {1'b0, time_seconds_i[10:0], time_subseconds_i[31:28]};
      end
      default: ;
    endcase
    if (filter_mode_q == nofx_pkg::MODE_SEQ || filter_mode_q == nofx_pkg::MODE_TIME) begin
      if (!params_ok || front_d.key < group_offset_q) begin
        front_d.decided = 1'b1;
        front_d.drop    = 1'b1;
      end else begin
        front_d.dvd = front_d.key - group_offset_q;
      end
    end
  end

  logic            cell_valid [NumCells+1];
  logic            cell_ready [NumCells+1];
  nofx_pkg::item_t cell_item  [NumCells+1];

  assign in_ready_o = !front_valid_q || cell_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      front_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      front_q <= front_d;
    end
  end

  assign cell_valid[0] = front_valid_q;
  assign cell_item[0]  = front_q;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    nofx_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (group_size_q),
      .valid_i   (cell_valid[i]),
      .ready_o   (cell_ready[i]),
      .item_i    (cell_item[i]),
      .valid_o   (cell_valid[i+1]),
      .ready_i   (cell_ready[i+1]),
      .item_o    (cell_item[i+1])
    );
  end

  assign cell_ready[NumCells] = out_ready_i;

  assign out_valid_o = cell_valid[NumCells];
  assign key_value_o = cell_item[NumCells].key;
  assign filtered_o  = cell_item[NumCells].decided ? cell_item[NumCells].drop
                                                   : (cell_item[NumCells].rem >= pass_count_q);

endmodule

FILE: rtl/nofx_checker.sv
module nofx_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [nofx_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input logic [15:0]                        cfg_data_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               filtered_o,
  input logic [15:0]                        key_value_o
);

  logic [1:0] mode_q;

  // mode as last written on the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= nofx_pkg::MODE_ALWAYS;
    end else if (cfg_valid_i && cfg_ready_o &&
                 cfg_index_i == nofx_pkg::REG_FILTER_MODE) begin
      mode_q <= cfg_data_i[1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(filtered_o) && $stable(key_value_o))
    else $error("result changed while stalled");

  a_always_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q == nofx_pkg::MODE_ALWAYS |-> filtered_o && key_value_o == 16'd0)
    else $error("always mode did not drop with zero key");

  a_never_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q == nofx_pkg::MODE_NEVER |-> !filtered_o && key_value_o == 16'd0)
    else $error("never mode dropped or gave a key");

  a_seq_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q == nofx_pkg::MODE_SEQ |-> key_value_o[15:14] == 2'b00)
    else $error("sequence key out of range");

endmodule

bind n_of_x_packet_filter_unit nofx_checker u_nofx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .filtered_o  (filtered_o),
  .key_value_o (key_value_o)
);
